// ===== sv/itt_pkg.sv =====
package itt_pkg;

    // Operation codes carried on the input channel
    typedef enum logic [1:0] {
        OP_PAINT = 2'd0,
        OP_CLEAR = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR_ALL = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEFT,
        ST_RIGHT,
        ST_COPY,
        ST_DONE
    } state_t;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== sv/itt_stream_if.sv =====
interface itt_stream_if #(
    parameter int unsigned DATA_BITS = 8
) (
    input logic clk
);
    logic valid;
    logic ready;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/interval_tag_table_core.sv =====
// Channel  Dir  Payload (msb to lsb)
// req      in   operation[1:0], first_offset, last_offset, mark_tag
// rsp      out  status, hit, found_tag
//
// Each pass walks the live entries one read a cycle. Lookup and clear-all take a scan
// pass and then the done state, which loads the result into the output register.
// Paint and clear add a left pass and a right pass, which build the new table in the
// spare bank. The copy state then swaps the bank and takes the new count, unless the
// new table overflowed.
// The entry memory is one synchronous array with one read per cycle. Reset clears the
// control registers (state, count, bank select, flags), not the memory or payload.
// A result waits in an output register. The next item is taken only after rsp has
// taken the result, so later while rsp stalls.
module interval_tag_table_core #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned OFFSET_BITS = 32,
    parameter int unsigned TAG_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    itt_stream_if.sink req,
    itt_stream_if.source rsp
);
    localparam int unsigned IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ENT_BITS = 2 * OFFSET_BITS + TAG_BITS;
    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

    // Two banks, the live table and the one being built
    logic [ENT_BITS-1:0] mem [2**(IDX_BITS+1)];

    itt_pkg::state_t state_reg, state_next;
    logic bank_reg;
    logic [CNT_BITS-1:0] used_reg, used_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] wcnt_reg, wcnt_next;
    logic over_reg, over_next;
    logic rd_vld_reg;
    logic [ENT_BITS-1:0] rd_data_reg;
    itt_pkg::op_t op_reg;
    logic [OFFSET_BITS-1:0] a_reg, b_reg, lo_reg, lo_next, hi_reg, hi_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic hit_reg, hit_next;
    logic [TAG_BITS-1:0] ftag_reg, ftag_next;
    logic out_vld_reg;
    logic [1+1+TAG_BITS-1:0] out_data_reg;

    logic [OFFSET_BITS-1:0] e_lo, e_hi, in_first, in_last;
    logic [TAG_BITS-1:0] e_tag;
    logic in_acc, rd_en, wr_en, done;
    logic [IDX_BITS:0] rd_addr, wr_addr;
    logic [ENT_BITS-1:0] wr_data;

    assign in_first = req.data[OFFSET_BITS+OFFSET_BITS+TAG_BITS-1 -: OFFSET_BITS];
    assign in_last = req.data[OFFSET_BITS+TAG_BITS-1 -: OFFSET_BITS];
    assign {e_lo, e_hi, e_tag} = rd_data_reg;
    assign req.ready = (state_reg == itt_pkg::ST_IDLE) && !out_vld_reg;
    assign in_acc = req.valid && req.ready;
    assign rsp.valid = out_vld_reg;
    assign rsp.data = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itt_pkg::ST_IDLE:
                if (in_acc) state_next = itt_pkg::ST_SCAN;
            itt_pkg::ST_SCAN:
                if (idx_reg == used_reg && !rd_vld_reg)
                    state_next = (op_reg == itt_pkg::OP_PAINT || op_reg == itt_pkg::OP_CLEAR)
                        ? itt_pkg::ST_LEFT : itt_pkg::ST_DONE;
                else if (idx_reg == used_reg)
                    state_next = state_reg;
            itt_pkg::ST_LEFT:
                if (idx_reg == used_reg && !rd_vld_reg) state_next = itt_pkg::ST_RIGHT;
            itt_pkg::ST_RIGHT:
                if (idx_reg == used_reg && !rd_vld_reg) state_next = itt_pkg::ST_COPY;
            itt_pkg::ST_COPY:
                state_next = itt_pkg::ST_DONE;
            itt_pkg::ST_DONE:
                state_next = itt_pkg::ST_IDLE;
            default:
                state_next = itt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        idx_next = idx_reg;
        wcnt_next = wcnt_reg;
        over_next = over_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        hit_next = hit_reg;
        ftag_next = ftag_reg;
        used_next = used_reg;
        rd_en = 1'b0;
        wr_en = 1'b0;
        wr_data = '0;
        done = 1'b0;
        rd_addr = {bank_reg, idx_reg[IDX_BITS-1:0]};
        wr_addr = {!bank_reg, wcnt_reg[IDX_BITS-1:0]};
        case (state_reg)
            itt_pkg::ST_SCAN, itt_pkg::ST_LEFT, itt_pkg::ST_RIGHT:
            begin
                if (idx_reg != used_reg)
                begin
                    rd_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (state_reg == itt_pkg::ST_SCAN)
                    begin
                        if (op_reg == itt_pkg::OP_PAINT && e_tag == tag_reg
                            && (e_lo <= b_reg || (b_reg != OFS_MAX && e_lo == b_reg + 1'b1))
                            && (e_hi >= a_reg || (a_reg != '0 && e_hi == a_reg - 1'b1)))
                        begin
                            if (e_lo < lo_next) lo_next = e_lo;
                            if (e_hi > hi_next) hi_next = e_hi;
                        end
                        if (op_reg == itt_pkg::OP_LOOKUP && !hit_reg
                            && e_lo <= a_reg && a_reg <= e_hi)
                        begin
                            hit_next = 1'b1;
                            ftag_next = e_tag;
                        end
                    end
                    else if (state_reg == itt_pkg::ST_LEFT && e_lo < lo_reg)
                    begin
                        wr_en = 1'b1;
                        wr_data = {e_lo, (e_hi < lo_reg) ? e_hi : lo_reg - 1'b1, e_tag};
                    end
                    else if (state_reg == itt_pkg::ST_RIGHT && e_hi > hi_reg)
                    begin
                        wr_en = 1'b1;
                        wr_data = {(e_lo > hi_reg) ? e_lo : hi_reg + 1'b1, e_hi, e_tag};
                    end
                end
                // painted entry goes in between the passes
                if (state_reg == itt_pkg::ST_LEFT && idx_reg == used_reg && !rd_vld_reg
                    && op_reg == itt_pkg::OP_PAINT)
                begin
                    wr_en = 1'b1;
                    wr_data = {lo_reg, hi_reg, tag_reg};
                end
                if (idx_reg == used_reg && !rd_vld_reg)
                    idx_next = '0;
            end
            itt_pkg::ST_COPY:
                if (!over_reg) used_next = wcnt_reg;
            itt_pkg::ST_DONE:
            begin
                done = 1'b1;
                if (op_reg == itt_pkg::OP_CLEAR_ALL) used_next = '0;
            end
            default:
                done = 1'b0;
        endcase
        if (wr_en)
        begin
            if (wcnt_reg == CNT_BITS'(TABLE_DEPTH)) over_next = 1'b1;
            else wcnt_next = wcnt_reg + 1'b1;
        end
    end

    // Entry memory, one read and one write a cycle
    always_ff @(posedge clk)
    begin
        if (rd_en) rd_data_reg <= mem[rd_addr];
        if (wr_en && wcnt_reg != CNT_BITS'(TABLE_DEPTH)) mem[wr_addr] <= wr_data;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg <= itt_pkg::op_t'(req.data[$bits(req.data)-1 -: 2]);
            a_reg <= (in_first > in_last) ? in_last : in_first;
            b_reg <= (in_first > in_last) ? in_first : in_last;
            lo_reg <= (in_first > in_last) ? in_last : in_first;
            hi_reg <= (in_first > in_last) ? in_first : in_last;
            tag_reg <= req.data[TAG_BITS-1:0];
            hit_reg <= 1'b0;
            ftag_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            hit_reg <= hit_next;
            ftag_reg <= ftag_next;
        end
        if (done)
            out_data_reg <= {(over_reg ? itt_pkg::STATUS_FULL : itt_pkg::STATUS_DONE),
                hit_reg, ftag_reg};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itt_pkg::ST_IDLE;
            bank_reg <= 1'b0;
            used_reg <= '0;
            idx_reg <= '0;
            wcnt_reg <= '0;
            over_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            idx_reg <= in_acc ? '0 : idx_next;
            wcnt_reg <= in_acc ? '0 : wcnt_next;
            over_reg <= in_acc ? 1'b0 : over_next;
            rd_vld_reg <= rd_en;
            if (state_reg == itt_pkg::ST_COPY && !over_reg) bank_reg <= !bank_reg;
            if (done) out_vld_reg <= 1'b1;
            else if (rsp.ready) out_vld_reg <= 1'b0;
        end
    end

    // Checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_BITS'(TABLE_DEPTH)) else $error("entry count beyond depth");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !req.ready) else $error("input taken while result waits");
    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itt_pkg::ST_COPY && over_reg) |=> $stable(used_reg) && $stable(bank_reg))
        else $error("refused edit changed the table");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("two results for one item");
endmodule
